/* rtl/prime_factorizer_trial_division_macros.svh */
// Assertion macros for the trial-division prime factorizer.
`ifndef PRIME_FACTORIZER_TRIAL_DIVISION_MACROS_SVH
`define PRIME_FACTORIZER_TRIAL_DIVISION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define PFTD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pftd: same-cycle check failed");
// Next-cycle implication.
`define PFTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pftd: next-cycle check failed");
`else
`define PFTD_ASSERT_NOW(lbl, ante, cons)
`define PFTD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/pftd_pkg.sv */
// Shared constants and types of the trial-division prime factorizer.
`default_nettype none
package pftd_pkg;

  localparam int PRIME_BITS     = 32;
  localparam int EXP_BITS       = 5;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FIELD_BITS     = 32;

  localparam logic [EXP_BITS-1:0] EXP_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } pftd_state_e;

endpackage
`default_nettype wire

/* rtl/pftd_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module pftd_divider #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 17
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [DIVIDEND_BITS-1:0] dividend_i,
  input  wire logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic                          done_o,
  output logic [DIVIDEND_BITS-1:0]      quotient_o,
  output logic [DIVISOR_BITS-1:0]       remainder_o
);

  localparam int CW = $clog2(DIVIDEND_BITS + 1);

  logic [DIVISOR_BITS-1:0]  acc_q, acc_d;
  logic [DIVISOR_BITS-1:0]  dsr_q;
  logic [DIVIDEND_BITS-1:0] quo_q, quo_d;
  logic [CW-1:0]            cnt_q;
  logic                     busy_q;
  logic                     done_q;

  logic [DIVISOR_BITS:0] trial;
  logic [DIVISOR_BITS:0] diff;
  logic                  fits;

  always_comb begin
    trial = {acc_q, quo_q[DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
    acc_d = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
    quo_d = {quo_q[DIVIDEND_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIVIDEND_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = acc_q;

endmodule
`default_nettype wire

/* rtl/prime_factorizer_trial_division.sv */
// Zero and one go out as a single item of their own; any other value takes one trial
// division per candidate divisor plus one per factor found, and each pair is emitted in
// turn. Throughput: one value at a time; the bit-serial divider retires one quotient
// bit per cycle.
// Reset: asynchronous, active low; returns to idle with no item pending.
`default_nettype none
`include "prime_factorizer_trial_division_macros.svh"
module prime_factorizer_trial_division
  import pftd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [FIELD_BITS-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PRIME_BITS-1:0]      prime_o,
  output logic [EXP_BITS-1:0]        exponent_o,
  output logic                       last_o
);

  // Working width of the value and of the trial divisor (up to ceil(sqrt) + 1).
  localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int DW = (VW + 1) / 2 + 1;

  pftd_state_e state_q, state_d;

  logic [VW-1:0]         rem_q, rem_d;
  logic [DW-1:0]         dsr_q, dsr_d;
  logic [EXP_BITS-1:0]   cnt_q, cnt_d;
  logic [PRIME_BITS-1:0] pend_prime_q, pend_prime_d;
  logic [EXP_BITS-1:0]   pend_exp_q, pend_exp_d;
  logic                  pend_last_q, pend_last_d;

  logic                  out_valid_q;
  logic [PRIME_BITS-1:0] out_prime_q;
  logic [EXP_BITS-1:0]   out_exp_q;
  logic                  out_last_q;
  logic                  out_load;

  logic          div_start;
  logic          div_done;
  logic [VW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic [VW-1:0] in_val;

  assign in_val = value_i[VW-1:0];

  pftd_divider #(
    .DIVIDEND_BITS(VW),
    .DIVISOR_BITS (DW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_d),
    .divisor_i  (dsr_d),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      dsr_q   <= DW'(2);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      dsr_q   <= dsr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_prime_q <= pend_prime_d;
    pend_exp_q   <= pend_exp_d;
    pend_last_q  <= pend_last_d;
  end

  always_comb begin
    state_d      = state_q;
    rem_d        = rem_q;
    dsr_d        = dsr_q;
    cnt_d        = cnt_q;
    pend_prime_d = pend_prime_q;
    pend_exp_d   = pend_exp_q;
    pend_last_d  = pend_last_q;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_val <= VW'(1)) begin
            // zero and one go straight out as their own single item
            pend_prime_d = PRIME_BITS'(in_val);
            pend_exp_d   = '0;
            pend_last_d  = 1'b1;
            state_d      = S_EMIT;
          end else begin
            rem_d     = in_val;
            dsr_d     = DW'(2);
            cnt_d     = '0;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (cnt_q == '0) begin
            if (VW'(dsr_q) > div_quo) begin
              // divisor squared exceeds what is left: the rest is prime
              pend_prime_d = PRIME_BITS'(rem_q);
              pend_exp_d   = EXP_BITS'(1);
              pend_last_d  = 1'b1;
              state_d      = S_EMIT;
            end else if (div_rem == '0) begin
              rem_d     = div_quo;
              cnt_d     = EXP_BITS'(1);
              div_start = 1'b1;
            end else begin
              dsr_d     = dsr_q + DW'(1);
              div_start = 1'b1;
            end
          end else if (div_rem == '0) begin
            rem_d     = div_quo;
            cnt_d     = (cnt_q == EXP_MAX) ? cnt_q : cnt_q + EXP_BITS'(1);
            div_start = 1'b1;
          end else begin
            pend_prime_d = PRIME_BITS'(dsr_q);
            pend_exp_d   = cnt_q;
            pend_last_d  = (rem_q == VW'(1));
            state_d      = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (pend_last_q) begin
            state_d = S_IDLE;
          end else begin
            dsr_d     = dsr_q + DW'(1);
            cnt_d     = '0;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: hold while stalled, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_prime_q <= pend_prime_q;
      out_exp_q   <= pend_exp_q;
      out_last_q  <= pend_last_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign prime_o     = out_prime_q;
  assign exponent_o  = out_exp_q;
  assign last_o      = out_last_q;

  `PFTD_ASSERT_NEXT(a_walk_starts, in_valid_i && !in_stall_o, state_q != S_IDLE)
  `PFTD_ASSERT_NOW(a_done_in_div, div_done, state_q == S_DIV)
  `PFTD_ASSERT_NOW(a_divisor_min, state_q == S_DIV, dsr_q >= DW'(2))
  `PFTD_ASSERT_NOW(a_zero_exp_last, out_valid_o && (exponent_o == '0), last_o)

endmodule
`default_nettype wire
